[src/swe_pkg.sv]
package swe_pkg;

	// Sizes of the candidate chain and the samples.
	localparam int WINDOW_MAX = 64;
	localparam int SAMPLE_W   = 32;
	localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
	localparam int CFG_W      = 7;
	localparam int CFG_IDX_W  = 1;

	// The front search looks at the chain in groups of this many cells.
	localparam int GROUP      = 8;
	localparam int NUM_GROUPS = (WINDOW_MAX + GROUP - 1) / GROUP;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FIND_MIN   = 1'b1;

	// Control broadcast from the top level to every swe_cell of the chain.
	typedef struct packed {
		logic                       step;
		logic                       restart;
		logic                       find_min;
		logic signed [SAMPLE_W-1:0] sample;
	} cell_ctl_t;

endpackage

[src/swe_cell.sv]
module swe_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  swe_pkg::cell_ctl_t                  ctl,
	input  logic                                in_range,
	input  logic signed [swe_pkg::SAMPLE_W-1:0] in_value,
	input  logic                                in_alive,
	input  logic                                in_block,
	output logic signed [swe_pkg::SAMPLE_W-1:0] value,
	output logic                                alive,
	output logic                                out_block
);

	logic signed [swe_pkg::SAMPLE_W-1:0] value_q;
	logic                                alive_q;
	logic                                eff;
	logic                                dom;
	logic                                kill;

	// The entry arriving from the younger neighbor is still a candidate if no restart
	// cleared it and its new age stays inside the window.
	assign eff = in_alive && !ctl.restart && in_range;

	// Dominated entries are not greater (max mode) or not less (min mode) than the sample.
	assign dom = ctl.find_min ? (in_value >= ctl.sample) : (in_value <= ctl.sample);

	// Removal runs from the young end and stops at the first surviving candidate.
	assign kill      = dom && !in_block;
	assign out_block = in_block || (eff && !dom);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b0;
		end else if (ctl.step) begin
			alive_q <= eff && !kill;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			value_q <= in_value;
		end
	end

	assign value = value_q;
	assign alive = alive_q;

endmodule

[src/swe_front.sv]
module swe_front (
	input  logic                                clk,
	input  logic                                load,
	input  logic signed [swe_pkg::SAMPLE_W-1:0] vals [swe_pkg::WINDOW_MAX],
	input  logic [swe_pkg::WINDOW_MAX-1:0]      alives,
	output logic signed [swe_pkg::SAMPLE_W-1:0] front
);

	logic signed [swe_pkg::SAMPLE_W-1:0] grp_val  [swe_pkg::NUM_GROUPS];
	logic [swe_pkg::NUM_GROUPS-1:0]      grp_any;
	logic signed [swe_pkg::SAMPLE_W-1:0] grp_val_s2 [swe_pkg::NUM_GROUPS];
	logic [swe_pkg::NUM_GROUPS-1:0]      grp_any_s2;

	// Within each group, pick the oldest live candidate (highest cell index).
	always_comb begin
		for (int g = 0; g < swe_pkg::NUM_GROUPS; g++) begin
			grp_val[g] = vals[g * swe_pkg::GROUP];
			grp_any[g] = 1'b0;
			for (int j = 0; j < swe_pkg::GROUP; j++) begin
				if ((g * swe_pkg::GROUP + j) < swe_pkg::WINDOW_MAX) begin
					if (alives[g * swe_pkg::GROUP + j]) begin
						grp_val[g] = vals[g * swe_pkg::GROUP + j];
						grp_any[g] = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_val_s2 <= grp_val;
			grp_any_s2 <= grp_any;
		end
	end

	// The oldest group holding a live candidate gives the front of the window.
	always_comb begin
		front = grp_val_s2[0];
		for (int g = 0; g < swe_pkg::NUM_GROUPS; g++) begin
			if (grp_any_s2[g]) begin
				front = grp_val_s2[g];
			end
		end
	end

endmodule

[src/sliding_window_extreme_top.sv]
// Sliding window maximum or minimum over a signed sample stream. Each accepted sample
// (tdata) enters a chain of candidate cells in which cell i holds the sample of age i
// together with a live flag; all cells compare against the new sample in the same
// cycle, so the whole candidate set updates in one step. A result follows its sample's
// transfer in order: the chain updates at the transfer edge, then the grouped search
// of the oldest live candidate is registered, and then the output register loads
// once it is free. One sample is in flight at a time, so the input accepts a new
// transfer only after the previous sample has left the search stages; a result waiting
// in the output register lets the next sample in, which then waits in the search
// stage until the output register frees up. tuser set to 1 restarts the
// sequence with that sample. A result is produced once window_len samples of the
// current sequence have been seen.
// window_len of 0 acts as 1 and values above the chain length act as the chain
// length; a shorter window takes effect at once, a longer one refills over time.
module sliding_window_extreme_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [swe_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [swe_pkg::CFG_W-1:0]            cfg_wdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [swe_pkg::SAMPLE_W-1:0]         s_tdata,   // [31:0] sample
	input  logic                                 s_tuser,   // [0] restart
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [swe_pkg::SAMPLE_W-1:0]         m_tdata    // [31:0] extreme
);

	logic [swe_pkg::CFG_W-1:0]           window_len_q;
	logic                                find_min_q;
	logic [swe_pkg::LEN_W-1:0]           seen_q;
	logic [swe_pkg::LEN_W-1:0]           wl_eff;
	logic [swe_pkg::LEN_W-1:0]           seen_base;
	logic [swe_pkg::LEN_W-1:0]           seen_next;
	logic                                emit;
	logic                                accept;
	logic                                out_free;
	logic                                valid_s1;
	logic                                emit_s1;
	logic                                valid_s2;
	logic                                emit_s2;
	logic                                m_tvalid_q;
	logic [swe_pkg::SAMPLE_W-1:0]        m_tdata_q;
	logic signed [swe_pkg::SAMPLE_W-1:0] head_value_q;
	logic                                head_valid_q;
	logic signed [swe_pkg::SAMPLE_W-1:0] front;
	swe_pkg::cell_ctl_t                  ctl;
	logic signed [swe_pkg::SAMPLE_W-1:0] cell_val [swe_pkg::WINDOW_MAX];
	logic [swe_pkg::WINDOW_MAX-1:0]      cell_alive;
	logic [swe_pkg::WINDOW_MAX-1:0]      blk;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= swe_pkg::CFG_W'(4);
			find_min_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				swe_pkg::REG_WINDOW_LEN: window_len_q <= cfg_wdata;
				swe_pkg::REG_FIND_MIN:   find_min_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Window length clamped to the range the chain can hold.
	always_comb begin
		if (window_len_q == '0) begin
			wl_eff = swe_pkg::LEN_W'(1);
		end else if (int'(window_len_q) > swe_pkg::WINDOW_MAX) begin
			wl_eff = swe_pkg::LEN_W'(swe_pkg::WINDOW_MAX);
		end else begin
			wl_eff = swe_pkg::LEN_W'(window_len_q);
		end
	end

	// Count of samples seen in this sequence, saturating at the window length.
	always_comb begin
		seen_base = s_tuser ? '0 : seen_q;
		if (seen_base > wl_eff) begin
			seen_base = wl_eff;
		end
		seen_next = (seen_base < wl_eff) ? seen_base + 1'b1 : seen_base;
		emit      = (seen_next >= wl_eff);
	end

	assign s_tready = !valid_s1 && !valid_s2;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			seen_q <= seen_next;
		end
	end

	// Cell zero: the newest sample, always a candidate once one has arrived.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
		end else if (accept) begin
			head_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_value_q <= s_tdata;
		end
	end

	assign ctl.step     = accept;
	assign ctl.restart  = s_tuser;
	assign ctl.find_min = find_min_q;
	assign ctl.sample   = s_tdata;

	assign cell_val[0]   = head_value_q;
	assign cell_alive[0] = head_valid_q;
	assign blk[0]        = 1'b0;

	// Chain of candidate cells; each step moves every entry one cell older.
	for (genvar i = 1; i < swe_pkg::WINDOW_MAX; i++) begin : g_cell
		logic in_range;

		assign in_range = (swe_pkg::LEN_W'(i) < wl_eff);

		swe_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.in_range  (in_range),
			.in_value  (cell_val[i-1]),
			.in_alive  (cell_alive[i-1]),
			.in_block  (blk[i-1]),
			.value     (cell_val[i]),
			.alive     (cell_alive[i]),
			.out_block (blk[i])
		);
	end

	// Grouped search for the oldest live candidate.
	swe_front u_front (
		.clk    (clk),
		.load   (valid_s1),
		.vals   (cell_val),
		.alives (cell_alive),
		.front  (front)
	);

	// Item tracking through the search stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			emit_s2  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				emit_s1 <= emit;
			end
			if (valid_s1) begin
				valid_s2 <= 1'b1;
				emit_s2  <= emit_s1;
			end else if (valid_s2 && (!emit_s2 || out_free)) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (valid_s2 && emit_s2 && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && emit_s2 && out_free) begin
			m_tdata_q <= front;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef NO_ASSERTIONS
	// Only one sample is in the search stages at any time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && valid_s2))
		else $error("two samples in the search stages");

	// After each accepted sample, the live candidates do not outnumber the window length.
	a_alive_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ($countones(cell_alive) <= int'(wl_eff)))
		else $error("more live candidates than the window holds");

	// A result appears only from a finished search that was due to emit.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s2 && emit_s2))
		else $error("result without a finished search");
`endif

endmodule
